// ===== sv/fsge_pkg.sv =====
`default_nettype none
package fsge_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    localparam int OP_W    = 2;
    localparam int COORD_W = 6;
    localparam int TYPE_W  = 2;
    localparam int COLOR_W = 32;
    localparam int STAMP_W = 16;
    localparam int CELL_W  = TYPE_W + COLOR_W + STAMP_W;

    localparam logic [TYPE_W-1:0]  T_VOID     = 2'd0;
    localparam logic [TYPE_W-1:0]  T_SAND     = 2'd1;
    localparam logic [TYPE_W-1:0]  T_WATER    = 2'd2;
    localparam logic [COLOR_W-1:0] VOID_COLOR = 32'hFF00_0000;

    localparam logic [CELL_W-1:0] VOID_CELL = {T_VOID, VOID_COLOR, {STAMP_W{1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 2'd0,
        OP_PASS = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    localparam logic [2:0] CAND_BELOW      = 3'd0;
    localparam logic [2:0] CAND_BELOW_L    = 3'd1;
    localparam logic [2:0] CAND_BELOW_R    = 3'd2;
    localparam logic [2:0] CAND_LEFT       = 3'd3;
    localparam logic [2:0] CAND_RIGHT      = 3'd4;
    localparam logic [2:0] CAND_LAST_SAND  = CAND_BELOW_R;
    localparam logic [2:0] CAND_LAST_WATER = CAND_RIGHT;

    typedef enum logic [1:0] {
        ADDR_POS = 2'd0,
        ADDR_IN  = 2'd1,
        ADDR_NB  = 2'd2
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_VOID = 2'd0,
        WD_SET  = 2'd1,
        WD_CUR  = 2'd2,
        WD_SRC  = 2'd3
    } wdata_sel_t;

    typedef struct packed {
        logic       in_ready;
        logic       pos_clr;
        logic       pos_inc;
        addr_sel_t  addr_sel;
        logic       rd_en;
        logic       wr_en;
        wdata_sel_t wd_sel;
        logic       cur_latch;
        logic       nb_latch;
        logic       cand_clr;
        logic       cand_inc;
        logic       swap_set;
        logic       res_latch;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        op_t  op;
        logic in_inside;
        logic last_cell;
        logic skip;
        logic movable;
        logic cand_ok;
        logic nb_inside;
        logic nb_void;
        logic nb_swap;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== sv/fsge_in_if.sv =====
`default_nettype none
interface fsge_in_if;
    logic                             valid;
    logic                             ready;
    logic [fsge_pkg::OP_W-1:0]        opcode;
    logic [fsge_pkg::COORD_W-1:0]     x_coord;
    logic [fsge_pkg::COORD_W-1:0]     y_coord;
    logic [fsge_pkg::TYPE_W-1:0]      new_type;
    logic [fsge_pkg::COLOR_W-1:0]     new_color;
    logic [fsge_pkg::STAMP_W-1:0]     frame;

    modport source (output valid, opcode, x_coord, y_coord, new_type, new_color, frame,
                    input ready);
    modport sink (input valid, opcode, x_coord, y_coord, new_type, new_color, frame,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/fsge_out_if.sv =====
`default_nettype none
interface fsge_out_if;
    logic                         valid;
    logic                         ready;
    logic [fsge_pkg::TYPE_W-1:0]  cell_type;
    logic [fsge_pkg::COLOR_W-1:0] cell_color;

    modport source (output valid, cell_type, cell_color, input ready);
    modport sink (input valid, cell_type, cell_color, output ready);
endinterface
`default_nettype wire

// ===== sv/fsge_ctrl.sv =====
`default_nettype none
module fsge_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fsge_pkg::sts_t sts,
    output fsge_pkg::cmd_t      cmd
);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_CLEAR   = 14'b00000000000010,
        ST_SET     = 14'b00000000000100,
        ST_RD      = 14'b00000000001000,
        ST_RD_WAIT = 14'b00000000010000,
        ST_CUR_RD  = 14'b00000000100000,
        ST_CUR_CHK = 14'b00000001000000,
        ST_NB_RD   = 14'b00000010000000,
        ST_NB_CHK  = 14'b00000100000000,
        ST_MV_A    = 14'b00001000000000,
        ST_MV_B    = 14'b00010000000000,
        ST_STAY    = 14'b00100000000000,
        ST_NEXT    = 14'b01000000000000,
        ST_DONE    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.addr_sel = fsge_pkg::ADDR_POS;
        cmd.wd_sel = fsge_pkg::WD_VOID;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_en = 1'b1;
                cmd.pos_inc = 1'b1;
                if (sts.last_cell)
                begin
                    cmd.pos_clr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.pos_clr = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = ST_DONE;
                    case (sts.op)
                        fsge_pkg::OP_SET:  state_next = ST_SET;
                        fsge_pkg::OP_PASS: state_next = ST_CUR_RD;
                        fsge_pkg::OP_READ: state_next = ST_RD;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_SET:
            begin
                cmd.addr_sel = fsge_pkg::ADDR_IN;
                cmd.wd_sel = fsge_pkg::WD_SET;
                cmd.wr_en = sts.in_inside;
                state_next = ST_DONE;
            end
            ST_RD:
            begin
                cmd.addr_sel = fsge_pkg::ADDR_IN;
                cmd.rd_en = 1'b1;
                state_next = sts.in_inside ? ST_RD_WAIT : ST_DONE;
            end
            ST_RD_WAIT:
            begin
                cmd.res_latch = 1'b1;
                state_next = ST_DONE;
            end
            ST_CUR_RD:
            begin
                cmd.rd_en = 1'b1;
                state_next = ST_CUR_CHK;
            end
            ST_CUR_CHK:
            begin
                cmd.cur_latch = 1'b1;
                cmd.cand_clr = 1'b1;
                if (sts.skip)
                begin
                    state_next = ST_NEXT;
                end
                else if (sts.movable)
                begin
                    state_next = ST_NB_RD;
                end
                else
                begin
                    state_next = ST_STAY;
                end
            end
            ST_NB_RD:
            begin
                cmd.addr_sel = fsge_pkg::ADDR_NB;
                if (!sts.cand_ok)
                begin
                    state_next = ST_STAY;
                end
                else if (!sts.nb_inside)
                begin
                    cmd.cand_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    state_next = ST_NB_CHK;
                end
            end
            ST_NB_CHK:
            begin
                cmd.nb_latch = 1'b1;
                if (sts.nb_void || sts.nb_swap)
                begin
                    cmd.swap_set = sts.nb_swap;
                    state_next = ST_MV_A;
                end
                else
                begin
                    cmd.cand_inc = 1'b1;
                    state_next = ST_NB_RD;
                end
            end
            ST_MV_A:
            begin
                cmd.addr_sel = fsge_pkg::ADDR_NB;
                cmd.wd_sel = fsge_pkg::WD_CUR;
                cmd.wr_en = 1'b1;
                state_next = ST_MV_B;
            end
            ST_MV_B:
            begin
                cmd.wd_sel = fsge_pkg::WD_SRC;
                cmd.wr_en = 1'b1;
                state_next = ST_NEXT;
            end
            ST_STAY:
            begin
                cmd.wd_sel = fsge_pkg::WD_CUR;
                cmd.wr_en = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (sts.last_cell)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                    state_next = ST_CUR_RD;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/fsge_dp.sv =====
`default_nettype none
module fsge_dp #(
    parameter int GridWidth  = fsge_pkg::GRID_WIDTH,
    parameter int GridHeight = fsge_pkg::GRID_HEIGHT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    fsge_in_if.sink             req,
    fsge_out_if.source          rsp,
    input  wire fsge_pkg::cmd_t cmd,
    output fsge_pkg::sts_t      sts
);

    localparam int Cells = GridWidth * GridHeight;
    localparam int AW    = $clog2(Cells);
    localparam int XW    = $clog2(GridWidth);
    localparam int YW    = $clog2(GridHeight);
    localparam int CW    = fsge_pkg::CELL_W;
    localparam int SW    = fsge_pkg::STAMP_W;
    localparam int KW    = fsge_pkg::COLOR_W;
    localparam int TW    = fsge_pkg::TYPE_W;

    localparam logic [AW-1:0] STEP_ROW   = AW'(GridWidth);
    localparam logic [AW-1:0] STEP_ROW_L = AW'(GridWidth - 1);
    localparam logic [AW-1:0] STEP_ROW_R = AW'(GridWidth + 1);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(Cells - 1);
    localparam logic [XW-1:0] LAST_X     = XW'(GridWidth - 1);
    localparam logic [YW-1:0] LAST_Y     = YW'(GridHeight - 1);

    logic [CW-1:0] mem [Cells];

    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [AW-1:0] lin_reg;
    logic [2:0]    cand_reg;
    logic          swap_reg;
    logic          out_valid_reg;

    fsge_pkg::op_t                op_reg;
    logic [fsge_pkg::COORD_W-1:0] xin_reg, yin_reg;
    logic [TW-1:0]                nt_reg;
    logic [KW-1:0]                nc_reg;
    logic [SW-1:0]                fr_reg;
    logic [CW-1:0]                rdata_reg, cur_reg, nb_reg;
    logic [TW-1:0]                res_type_reg, out_type_reg;
    logic [KW-1:0]                res_color_reg, out_color_reg;

    logic          accept;
    logic          in_inside;
    logic [AW-1:0] in_addr, nb_addr, addr;
    logic          nb_inside;
    logic [CW-1:0] wdata;
    logic [TW-1:0] rd_type, cur_type;

    assign accept    = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;
    assign in_inside = (int'(xin_reg) < GridWidth) && (int'(yin_reg) < GridHeight);
    assign in_addr   = AW'(int'(yin_reg) * GridWidth + int'(xin_reg));
    assign rd_type   = rdata_reg[CW-1 -: TW];
    assign cur_type  = cur_reg[CW-1 -: TW];

    always_comb
    begin
        nb_inside = 1'b0;
        nb_addr = lin_reg;
        case (cand_reg)
            fsge_pkg::CAND_BELOW:
            begin
                nb_inside = y_reg != LAST_Y;
                nb_addr = lin_reg + STEP_ROW;
            end
            fsge_pkg::CAND_BELOW_L:
            begin
                nb_inside = (y_reg != LAST_Y) && (x_reg != '0);
                nb_addr = lin_reg + STEP_ROW_L;
            end
            fsge_pkg::CAND_BELOW_R:
            begin
                nb_inside = (y_reg != LAST_Y) && (x_reg != LAST_X);
                nb_addr = lin_reg + STEP_ROW_R;
            end
            fsge_pkg::CAND_LEFT:
            begin
                nb_inside = x_reg != '0;
                nb_addr = lin_reg - AW'(1);
            end
            fsge_pkg::CAND_RIGHT:
            begin
                nb_inside = x_reg != LAST_X;
                nb_addr = lin_reg + AW'(1);
            end
            default:
            begin
                nb_inside = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.addr_sel)
            fsge_pkg::ADDR_IN: addr = in_addr;
            fsge_pkg::ADDR_NB: addr = nb_addr;
            default:           addr = lin_reg;
        endcase
        case (cmd.wd_sel)
            fsge_pkg::WD_SET: wdata = {nt_reg, nc_reg, {SW{1'b0}}};
            fsge_pkg::WD_CUR: wdata = cur_reg;
            fsge_pkg::WD_SRC: wdata = swap_reg ? nb_reg : fsge_pkg::VOID_CELL;
            default:          wdata = fsge_pkg::VOID_CELL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            lin_reg <= '0;
            cand_reg <= '0;
            swap_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg <= fsge_pkg::OP_NOP;
        end
        else
        begin
            if (cmd.pos_clr)
            begin
                x_reg <= '0;
                y_reg <= '0;
                lin_reg <= '0;
            end
            else if (cmd.pos_inc)
            begin
                lin_reg <= lin_reg + AW'(1);
                if (x_reg == LAST_X)
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + YW'(1);
                end
                else
                begin
                    x_reg <= x_reg + XW'(1);
                end
            end
            if (cmd.cand_clr)
            begin
                cand_reg <= '0;
            end
            else if (cmd.cand_inc)
            begin
                cand_reg <= cand_reg + 3'd1;
            end
            if (cmd.nb_latch)
            begin
                swap_reg <= cmd.swap_set;
            end
            if (accept)
            begin
                op_reg <= fsge_pkg::op_t'(req.opcode);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xin_reg <= req.x_coord;
            yin_reg <= req.y_coord;
            nt_reg <= req.new_type;
            nc_reg <= req.new_color;
            fr_reg <= req.frame;
            res_type_reg <= '0;
            res_color_reg <= '0;
        end
        else if (cmd.res_latch)
        begin
            res_type_reg <= rd_type;
            res_color_reg <= rdata_reg[SW +: KW];
        end
        if (cmd.cur_latch)
        begin
            cur_reg <= {rdata_reg[CW-1:SW], fr_reg};
        end
        if (cmd.nb_latch)
        begin
            nb_reg <= rdata_reg;
        end
        if (cmd.out_load)
        begin
            out_type_reg <= res_type_reg;
            out_color_reg <= res_color_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_type  = out_type_reg;
    assign rsp.cell_color = out_color_reg;

    always_comb
    begin
        sts.in_valid  = req.valid;
        sts.op        = accept ? fsge_pkg::op_t'(req.opcode) : op_reg;
        sts.in_inside = in_inside;
        sts.last_cell = lin_reg == LAST_ADDR;
        sts.skip      = rdata_reg[SW-1:0] >= fr_reg;
        sts.movable   = (rd_type == fsge_pkg::T_SAND) || (rd_type == fsge_pkg::T_WATER);
        sts.cand_ok   = (cur_type == fsge_pkg::T_SAND) ?
                        (cand_reg <= fsge_pkg::CAND_LAST_SAND) :
                        (cand_reg <= fsge_pkg::CAND_LAST_WATER);
        sts.nb_inside = nb_inside;
        sts.nb_void   = rd_type == fsge_pkg::T_VOID;
        sts.nb_swap   = (cand_reg == fsge_pkg::CAND_BELOW) &&
                        (cur_type == fsge_pkg::T_SAND) && (rd_type == fsge_pkg::T_WATER);
        sts.out_free  = !out_valid_reg || rsp.ready;
    end

endmodule
`default_nettype wire

// ===== sv/falling_sand_grid_engine.sv =====
`default_nettype none
// Port   Dir   Role     Payload
// req    in    sink     opcode, x_coord, y_coord, new_type, new_color, frame
// rsp    out   source   cell_type, cell_color
//
// A pass works cell by cell, all on the single grid memory port:
// one read per cell, one read per neighbor tried, at most two writes.
// After reset a clearing sweep writes every cell,
// during which req.ready stays low.
// A result waits in the output register; a new item is taken meanwhile.
module falling_sand_grid_engine #(
    parameter int GridWidth  = fsge_pkg::GRID_WIDTH,
    parameter int GridHeight = fsge_pkg::GRID_HEIGHT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsge_in_if.sink    req,
    fsge_out_if.source rsp
);

    fsge_pkg::cmd_t cmd;
    fsge_pkg::sts_t sts;

    fsge_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    fsge_dp #(
        .GridWidth  (GridWidth),
        .GridHeight (GridHeight)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

    a_no_write_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !req.ready)
        else $error("grid write while taking items");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("item taken while busy");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp.valid)
        else $error("result load lost");

endmodule
`default_nettype wire
